### hdl/sobel_edge_threshold_macros.svh
// Assertion helpers shared by the checked RTL files.
`ifndef SOBEL_EDGE_THRESHOLD_MACROS_SVH
`define SOBEL_EDGE_THRESHOLD_MACROS_SVH

// Condition that must hold on every clock edge outside reset.
`define SOBEL_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Condition that must hold in the cycle after a trigger.
`define SOBEL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Condition that must hold in the same cycle as a trigger.
`define SOBEL_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

### hdl/sobel_pkg.sv
`timescale 1ns / 1ps
package sobel_pkg;

  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;
  localparam int FIFO_DEPTH     = 8;

  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  localparam int THR_W  = 21;
  localparam int SIZE_W = 9;

  localparam logic [THR_W-1:0]  THRESH_RESET = THR_W'(32581);
  localparam logic [SIZE_W-1:0] SIZE_RESET   = SIZE_W'(256);

  localparam logic [7:0] EDGE_LEVEL = 8'd0;
  localparam logic [7:0] FLAT_LEVEL = 8'd255;

  // register index = paddr[3:2]
  localparam logic [1:0] REG_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_WIDTH     = 2'd1;
  localparam logic [1:0] REG_HEIGHT    = 2'd2;

  typedef struct packed {
    logic       kind;      // 1: drain tick
    logic [7:0] pixel_in;
  } pix_word_t;

  typedef struct packed {
    logic [7:0] pixel_out;
    logic       frame_end;
  } edge_word_t;

endpackage

### hdl/sobel_line_mem.sv
`timescale 1ns / 1ps
module sobel_line_mem #(
  parameter int DEPTH = 256,
  parameter int AW    = 8,
  parameter int DW    = 16
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data
);

  logic [DW-1:0] mem [DEPTH];

  // read-first: a same-cycle write to the read address returns old data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

endmodule

### hdl/sobel_out_fifo.sv
`timescale 1ns / 1ps
module sobel_out_fifo #(
  parameter int DEPTH = sobel_pkg::FIFO_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  sobel_pkg::edge_word_t push_word,
  input  logic                  pop,
  output sobel_pkg::edge_word_t head,
  output logic                  not_empty,
  output logic                  full
);
  import sobel_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  edge_word_t     store [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;

  assign not_empty = (count != '0);
  assign full      = (count == CW'(DEPTH));
  assign head      = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      count <= count + CW'(push) - CW'(pop);
    end
  end

endmodule

### hdl/sobel_edge_threshold.sv
// Stages 1, 2 and 3 carry a result into the output queue after the word completing its
// window (one row and one pixel after its own pixel); pix_ready gates 1 word per cycle.
// Rate is set by the line memory: one read and one write-back per word, forwarded
// when consecutive words hit the same column. Credits from an 8-word output queue
// drop pix_ready once 8 results are claimed across pipeline and queue together.
// Reset: position, window, queue and registers clear at once; line memory is not cleared.
`timescale 1ns / 1ps
`include "sobel_edge_threshold_macros.svh"
module sobel_edge_threshold #(
  parameter int MAX_WIDTH  = sobel_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = sobel_pkg::DEF_MAX_HEIGHT
) (
  input  logic                          clk,
  input  logic                          rst,
  // pixel input channel
  input  logic                          pix_valid,
  output logic                          pix_ready,
  input  sobel_pkg::pix_word_t          pix_word,
  // edge result channel
  output logic                          edge_valid,
  input  logic                          edge_ready,
  output sobel_pkg::edge_word_t         edge_word,
  // register port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sobel_pkg::PADDR_W-1:0] paddr,
  input  logic [sobel_pkg::PDATA_W-1:0] pwdata,
  output logic [sobel_pkg::PDATA_W-1:0] prdata,
  output logic                          pready
);
  import sobel_pkg::*;

  // column counter must hold the width itself, row counter up to height+2
  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW = $clog2(MAX_HEIGHT + 3);
  localparam int OW = $clog2(FIFO_DEPTH + 1);

  // ---------------------------------------------------------------------------
  // Register file
  // ---------------------------------------------------------------------------
  logic [THR_W-1:0]  magnitude_threshold;
  logic [SIZE_W-1:0] frame_width;
  logic [SIZE_W-1:0] frame_height;
  logic              cfg_wr;
  logic [1:0]        cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      magnitude_threshold <= THRESH_RESET;
      frame_width         <= SIZE_RESET;
      frame_height        <= SIZE_RESET;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_THRESHOLD: magnitude_threshold <= pwdata[THR_W-1:0];
        REG_WIDTH:     frame_width         <= pwdata[SIZE_W-1:0];
        REG_HEIGHT:    frame_height        <= pwdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_THRESHOLD: prdata = PDATA_W'(magnitude_threshold);
      REG_WIDTH:     prdata = PDATA_W'(frame_width);
      REG_HEIGHT:    prdata = PDATA_W'(frame_height);
      default:       prdata = '0;
    endcase
  end

  // Sizes in use: zero counts as one, oversize clamps to the maximum.
  logic [CW-1:0] w_eff;
  logic [RW-1:0] h_eff;
  logic [RW-1:0] hp1;

  always_comb begin
    if (frame_width == '0) begin
      w_eff = CW'(1);
    end else if (32'(frame_width) > MAX_WIDTH) begin
      w_eff = CW'(MAX_WIDTH);
    end else begin
      w_eff = CW'(frame_width);
    end
    if (frame_height == '0) begin
      h_eff = RW'(1);
    end else if (32'(frame_height) > MAX_HEIGHT) begin
      h_eff = RW'(MAX_HEIGHT);
    end else begin
      h_eff = RW'(frame_height);
    end
    hp1 = h_eff + RW'(1);
  end

  // ---------------------------------------------------------------------------
  // Stage 0: raster position, result decision, line memory read
  // ---------------------------------------------------------------------------
  logic [CW-1:0] col;         // input raster column
  logic [RW-1:0] row;         // input raster row
  logic          clr_pend;    // window restarts with the next word
  logic [OW-1:0] occ;         // result slots claimed in pipeline plus queue

  logic          acc;
  logic          fifo_pop;
  logic [CW-1:0] c1, c0, cn, col_next;
  logic [RW-1:0] r1, r0, row_next;
  logic          restart0, case1, case2;
  logic          res0, last0, top0, bot0, left0, right0;

  assign pix_ready = (occ < OW'(FIFO_DEPTH));
  assign acc       = pix_valid && pix_ready;

  always_comb begin
    // a column past the width (width shrank) starts the next row
    if (col >= w_eff) begin
      c1 = '0;
      r1 = row + RW'(1);
    end else begin
      c1 = col;
      r1 = row;
    end
    // beyond the last drain word: fresh frame
    restart0 = (r1 > hp1) || ((r1 == hp1) && (c1 != '0));
    c0 = restart0 ? '0 : c1;
    r0 = restart0 ? '0 : r1;

    // the result is the pixel one row up and one column left, or the row end
    case1  = (c0 != '0) && (r0 != '0);
    case2  = (c0 == '0) && (r0 >= RW'(2));
    res0   = case1 ? (r0 <= h_eff) : (case2 && (r0 <= hp1));
    last0  = case2 && (r0 == hp1);
    top0   = case1 ? (r0 == RW'(1)) : (r0 == RW'(2));
    bot0   = case1 ? (r0 >= h_eff) : (r0 >= hp1);
    left0  = case1 ? (c0 == CW'(1)) : (w_eff == CW'(1));
    right0 = !case1;

    cn = c0 + CW'(1);
    if (res0 && last0) begin
      col_next = '0;
      row_next = '0;
    end else if (cn >= w_eff) begin
      col_next = '0;
      row_next = r0 + RW'(1);
    end else begin
      col_next = cn;
      row_next = r0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col      <= '0;
      row      <= '0;
      clr_pend <= 1'b0;
      occ      <= '0;
    end else begin
      if (acc) begin
        col      <= col_next;
        row      <= row_next;
        clr_pend <= res0 && last0;
      end
      occ <= occ + OW'(acc && res0) - OW'(fifo_pop);
    end
  end

  // ---------------------------------------------------------------------------
  // Line memory: {upper row, middle row} per column
  // ---------------------------------------------------------------------------
  logic [15:0]   mem_rd;
  logic [15:0]   wb_data;     // write-back word of the stage-1 column
  logic [AW-1:0] rd_addr;

  assign rd_addr = c0[AW-1:0];

  // stage-1 registers
  logic          s1_busy;
  logic [AW-1:0] s1_col;
  logic          s1_ge1, s1_ge2, s1_clr;
  logic [7:0]    s1_pix;
  logic          s1_res, s1_last, s1_top, s1_bot, s1_left, s1_right;
  logic          s1_fwd;
  logic [15:0]   s1_fwd_data;

  sobel_line_mem #(
    .DEPTH (MAX_WIDTH),
    .AW    (AW),
    .DW    (16)
  ) u_line_mem (
    .clk     (clk),
    .rd_en   (acc),
    .rd_addr (rd_addr),
    .rd_data (mem_rd),
    .wr_en   (s1_busy),
    .wr_addr (s1_col),
    .wr_data (wb_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_busy <= 1'b0;
    end else begin
      s1_busy <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_col      <= rd_addr;
      s1_ge1      <= (r0 >= RW'(1));
      s1_ge2      <= (r0 >= RW'(2));
      s1_clr      <= clr_pend || restart0;
      s1_pix      <= pix_word.kind ? 8'd0 : pix_word.pixel_in;
      s1_res      <= res0;
      s1_last     <= last0;
      s1_top      <= top0;
      s1_bot      <= bot0;
      s1_left     <= left0;
      s1_right    <= right0;
      // the memory reads old data when stage 1 writes the same column now
      s1_fwd      <= s1_busy && (s1_col == rd_addr);
      s1_fwd_data <= wb_data;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: window shift, write-back, gradients
  // ---------------------------------------------------------------------------
  logic [7:0]  win      [3][3];   // [row][col], col 2 newest
  logic [7:0]  win_next [3][3];
  logic [7:0]  pm       [3][3];
  logic [15:0] line_word;
  logic [9:0]  col_l, col_r, row_t, row_b;
  logic signed [10:0] gx, gy;

  assign line_word = s1_fwd ? s1_fwd_data : mem_rd;
  // upper <= middle, middle <= new pixel
  assign wb_data   = {line_word[7:0], s1_pix};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      win_next[i][0] = s1_clr ? 8'd0 : win[i][1];
      win_next[i][1] = s1_clr ? 8'd0 : win[i][2];
    end
    win_next[0][2] = s1_ge2 ? line_word[15:8] : 8'd0;
    win_next[1][2] = s1_ge1 ? line_word[7:0]  : 8'd0;
    win_next[2][2] = s1_pix;

    // neighbors outside the frame read as zero
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if ((i == 0 && s1_top) || (i == 2 && s1_bot) ||
            (j == 0 && s1_left) || (j == 2 && s1_right)) begin
          pm[i][j] = 8'd0;
        end else begin
          pm[i][j] = win_next[i][j];
        end
      end
    end

    col_l = 10'(pm[0][0]) + {1'b0, pm[1][0], 1'b0} + 10'(pm[2][0]);
    col_r = 10'(pm[0][2]) + {1'b0, pm[1][2], 1'b0} + 10'(pm[2][2]);
    row_t = 10'(pm[0][0]) + {1'b0, pm[0][1], 1'b0} + 10'(pm[0][2]);
    row_b = 10'(pm[2][0]) + {1'b0, pm[2][1], 1'b0} + 10'(pm[2][2]);
    gx    = $signed({1'b0, col_r}) - $signed({1'b0, col_l});
    gy    = $signed({1'b0, row_b}) - $signed({1'b0, row_t});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win[i][j] <= 8'd0;
        end
      end
    end else if (s1_busy) begin
      win <= win_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: squares; stage 3: sum and threshold
  // ---------------------------------------------------------------------------
  logic               s2_valid, s2_last;
  logic signed [10:0] s2_gx, s2_gy;
  logic signed [21:0] sqx_full, sqy_full;
  logic               s3_valid, s3_last;
  logic [19:0]        s3_sqx, s3_sqy;
  logic [20:0]        mag;
  edge_word_t         push_word;
  logic               fifo_full;

  assign sqx_full = s2_gx * s2_gx;
  assign sqy_full = s2_gy * s2_gy;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      s2_valid <= s1_busy && s1_res;
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    s2_gx   <= gx;
    s2_gy   <= gy;
    s2_last <= s1_last;
    s3_sqx  <= sqx_full[19:0];
    s3_sqy  <= sqy_full[19:0];
    s3_last <= s2_last;
  end

  assign mag = 21'(s3_sqx) + 21'(s3_sqy);

  always_comb begin
    push_word.pixel_out = (mag >= magnitude_threshold) ? EDGE_LEVEL : FLAT_LEVEL;
    push_word.frame_end = s3_last;
  end

  // ---------------------------------------------------------------------------
  // Output queue: decouples the pipeline from output stalls
  // ---------------------------------------------------------------------------
  assign fifo_pop = edge_valid && edge_ready;

  sobel_out_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (s3_valid),
    .push_word (push_word),
    .pop       (fifo_pop),
    .head      (edge_word),
    .not_empty (edge_valid),
    .full      (fifo_full)
  );

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  `SOBEL_ASSERT_ALWAYS(a_no_overflow, !(s3_valid && fifo_full && !fifo_pop), "result queue overflow")
  `SOBEL_ASSERT_NEXT(a_frame_restart, acc && res0 && last0, (col == '0) && (row == '0) && clr_pend, "position not cleared after frame end")
  `SOBEL_ASSERT_SAME(a_col_in_range, s1_busy, CW'(s1_col) < w_eff, "write-back column beyond frame width")
  `SOBEL_ASSERT_SAME(a_credit_bound, s3_valid, occ != '0, "result without a claimed slot")

endmodule
